@@ hw/rtl/smi_pkg.sv @@
// smi_pkg: shared types and codes for the selective message inbox.
// No dependencies.
package smi_pkg;

	localparam int INBOX_DEPTH_DEF = 16;
	localparam int RING_DEPTH_DEF  = 16;

	typedef enum logic [1:0] {
		OP_DELIVER = 2'd0,
		OP_POLL    = 2'd1,
		OP_TYPED   = 2'd2,
		OP_RSVD    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_READY     = 3'd0,
		ST_NONE      = 3'd1,
		ST_FULL      = 3'd2,
		ST_DELIVERED = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_IB_RD,
		S_IB_CHK,
		S_RG_RD,
		S_RG_CHK,
		S_CMP_RD,
		S_CMP_WR,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic [31:0] mtype;
		logic [15:0] sender;
		logic [63:0] payload;
	} msg_t;

endpackage

@@ hw/rtl/selective_message_inbox.sv @@
// Selective message inbox: arrival ring feeding an ordered deferred inbox.
// Deliver goes straight to the result; plain poll takes the inbox head, compacting
// the inbox, or the ring head if the inbox is empty; typed poll scans the inbox
// (compacting on a match), then drains ring messages, deferring non-matches to the
// inbox tail. One item in flight; the next is taken the cycle after the result leaves.
// Reset (arst_n low) clears counts, pointers and the FSM; memory contents are kept.
// Depends on smi_pkg.
module selective_message_inbox #(
	parameter int INBOX_DEPTH = smi_pkg::INBOX_DEPTH_DEF,
	parameter int RING_DEPTH  = smi_pkg::RING_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: op[1:0], msg_type[33:2], msg_sender[49:34], msg_payload[113:50],
	// want_type[145:114], want_sender[162:146], zero fill to 168
	input  logic [167:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: status[2:0], out_type[34:3], out_sender[50:35],
	// out_payload[114:51], pending_count[119:115]
	output logic [119:0] m_tdata
);

	localparam int IW = (INBOX_DEPTH > 1) ? $clog2(INBOX_DEPTH) : 1;
	localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int IC = $clog2(INBOX_DEPTH + 1);
	localparam int RC = $clog2(RING_DEPTH + 1);

	// storage: one simple dual-port RAM per queue
	smi_pkg::msg_t inbox_mem [INBOX_DEPTH];
	smi_pkg::msg_t ring_mem  [RING_DEPTH];

	smi_pkg::fsm_t state_q, state_d;

	logic [IC-1:0] inbox_used_q;
	logic [RC-1:0] ring_used_q;
	logic [RW-1:0] ring_head_q;
	logic [IC-1:0] idx_q;      // scan / compaction index
	logic [IC-1:0] drained_q;  // ring messages deferred to the inbox this poll
	logic [1:0]    op_q;
	logic [31:0]   want_type_q;
	logic signed [16:0] want_sender_q;
	smi_pkg::msg_t msg_q, got_q;
	logic [2:0]    status_q;
	logic          m_valid_q;
	logic [119:0]  m_data_q;

	// registered memory reads
	smi_pkg::msg_t ib_rd_s1, rg_rd_s1;
	logic [IW-1:0] ib_raddr;

	// memory write paths: compaction, deferral and delivery
	logic          ib_we;
	logic [IW-1:0] ib_waddr;
	smi_pkg::msg_t ib_wdata;
	logic          rg_we;
	logic [RW-1:0] rg_waddr;

	logic [RW-1:0] ring_tail;
	logic          ib_match, rg_match;

	function automatic logic is_match(smi_pkg::msg_t m, logic [31:0] wt,
			logic signed [16:0] ws);
		logic snd_ok;
		snd_ok = (ws <= 17'sd0) || ({1'b0, m.sender} == ws);
		return (m.mtype == wt) && snd_ok;
	endfunction

	assign ib_match = is_match(ib_rd_s1, want_type_q, want_sender_q);
	assign rg_match = is_match(rg_rd_s1, want_type_q, want_sender_q);
	assign ring_tail = RW'((RC+1)'(ring_head_q) + (RC+1)'(ring_used_q)
		- ((RC+1)'(ring_head_q) + (RC+1)'(ring_used_q) >= (RC+1)'(RING_DEPTH)
		? (RC+1)'(RING_DEPTH) : '0));

	assign s_tready = (state_q == smi_pkg::S_IDLE) && !m_valid_q;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// memories
	always_ff @(posedge clk) begin
		if (ib_we) begin
			inbox_mem[ib_waddr] <= ib_wdata;
		end
		ib_rd_s1 <= inbox_mem[ib_raddr];
	end

	always_ff @(posedge clk) begin
		if (rg_we) begin
			ring_mem[rg_waddr] <= msg_q;
		end
		rg_rd_s1 <= ring_mem[ring_head_q];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smi_pkg::S_IDLE: begin
				if (s_tvalid && s_tready) begin
					unique case (smi_pkg::op_t'(s_tdata[1:0]))
						smi_pkg::OP_DELIVER: state_d = smi_pkg::S_DONE;
						smi_pkg::OP_POLL: begin
							if (inbox_used_q != '0)     state_d = smi_pkg::S_IB_RD;
							else if (ring_used_q != '0) state_d = smi_pkg::S_RG_RD;
							else                        state_d = smi_pkg::S_DONE;
						end
						smi_pkg::OP_TYPED: begin
							if (inbox_used_q != '0) state_d = smi_pkg::S_IB_RD;
							else                    state_d = smi_pkg::S_RG_RD;
						end
						default: state_d = smi_pkg::S_DONE;
					endcase
				end
			end
			smi_pkg::S_IB_RD:  state_d = smi_pkg::S_IB_CHK;
			smi_pkg::S_IB_CHK: begin
				priority if (op_q == smi_pkg::OP_POLL || ib_match)
					state_d = smi_pkg::S_CMP_RD;
				else if (idx_q + 1'b1 < inbox_used_q)
					state_d = smi_pkg::S_IB_RD;
				else
					state_d = smi_pkg::S_RG_RD;
			end
			smi_pkg::S_RG_RD: begin
				priority if (op_q == smi_pkg::OP_POLL) state_d = smi_pkg::S_RG_CHK;
				else if (drained_q >= IC'(INBOX_DEPTH)) state_d = smi_pkg::S_DONE;
				else if (inbox_used_q >= IC'(INBOX_DEPTH)) state_d = smi_pkg::S_DONE;
				else if (ring_used_q == '0) state_d = smi_pkg::S_DONE;
				else state_d = smi_pkg::S_RG_CHK;
			end
			smi_pkg::S_RG_CHK: begin
				if (op_q == smi_pkg::OP_POLL || rg_match) state_d = smi_pkg::S_DONE;
				else                                      state_d = smi_pkg::S_RG_RD;
			end
			smi_pkg::S_CMP_RD: begin
				if (idx_q + 1'b1 < inbox_used_q) state_d = smi_pkg::S_CMP_WR;
				else                              state_d = smi_pkg::S_DONE;
			end
			smi_pkg::S_CMP_WR: state_d = smi_pkg::S_CMP_RD;
			smi_pkg::S_DONE:   state_d = smi_pkg::S_IDLE;
			default:           state_d = smi_pkg::S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		ib_raddr = IW'(idx_q);
		ib_we    = 1'b0;
		ib_waddr = IW'(idx_q);
		ib_wdata = ib_rd_s1;
		rg_we    = 1'b0;
		rg_waddr = ring_tail;
		unique case (state_q)
			smi_pkg::S_CMP_RD: ib_raddr = IW'(idx_q + 1'b1);
			smi_pkg::S_CMP_WR: ib_we = 1'b1;
			smi_pkg::S_RG_CHK: begin
				// defer non-match to inbox tail
				ib_we    = (op_q != smi_pkg::OP_POLL) && !rg_match;
				ib_waddr = IW'(inbox_used_q);
				ib_wdata = rg_rd_s1;
			end
			smi_pkg::S_DONE: rg_we = (op_q == smi_pkg::OP_DELIVER)
				&& (status_q == smi_pkg::ST_DELIVERED);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= smi_pkg::S_IDLE;
			inbox_used_q <= '0;
			ring_used_q  <= '0;
			ring_head_q  <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				smi_pkg::S_IDLE: begin
					if (s_tvalid && s_tready) begin
						op_q          <= s_tdata[1:0];
						msg_q         <= {s_tdata[33:2], s_tdata[49:34], s_tdata[113:50]};
						want_type_q   <= s_tdata[145:114];
						want_sender_q <= s_tdata[162:146];
						idx_q         <= '0;
						drained_q     <= '0;
						got_q         <= '0;
						status_q      <= smi_pkg::ST_NONE;
						if (s_tdata[1:0] == smi_pkg::OP_DELIVER) begin
							status_q <= (ring_used_q >= RC'(RING_DEPTH))
								? smi_pkg::ST_OVERFLOW : smi_pkg::ST_DELIVERED;
						end
					end
				end
				smi_pkg::S_IB_CHK: begin
					if (op_q == smi_pkg::OP_POLL || ib_match) begin
						got_q    <= ib_rd_s1;
						status_q <= smi_pkg::ST_READY;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				smi_pkg::S_RG_RD: begin
					if (op_q == smi_pkg::OP_TYPED && drained_q < IC'(INBOX_DEPTH)
							&& inbox_used_q >= IC'(INBOX_DEPTH)) begin
						status_q <= smi_pkg::ST_FULL;
					end
				end
				smi_pkg::S_RG_CHK: begin
					ring_used_q <= ring_used_q - 1'b1;
					ring_head_q <= (32'(ring_head_q) == RING_DEPTH - 1) ? '0
						: ring_head_q + 1'b1;
					if (op_q == smi_pkg::OP_POLL || rg_match) begin
						got_q    <= rg_rd_s1;
						status_q <= smi_pkg::ST_READY;
					end else begin
						inbox_used_q <= inbox_used_q + 1'b1;
						drained_q    <= drained_q + 1'b1;
					end
				end
				smi_pkg::S_CMP_RD: begin
					if (!(idx_q + 1'b1 < inbox_used_q)) begin
						inbox_used_q <= inbox_used_q - 1'b1;
					end
				end
				smi_pkg::S_CMP_WR: idx_q <= idx_q + 1'b1;
				smi_pkg::S_DONE: begin
					if (rg_we) begin
						ring_used_q <= ring_used_q + 1'b1;
					end
					m_valid_q <= 1'b1;
					m_data_q  <= {5'(inbox_used_q), got_q.payload, got_q.sender,
						got_q.mtype, status_q};
				end
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/smi_checker.sv @@
// smi_checker: port-level checks for selective_message_inbox.
// Depends on smi_pkg; bound to the top level below.
module smi_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [167:0] s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [119:0] m_tdata
);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("accepted while result waits");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != smi_pkg::ST_READY |-> m_tdata[114:3] == '0)
		else $error("nonzero message on non-ready");

	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[119:115] <= 5'd16) else $error("pending out of range");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("ready right after accept");

endmodule

bind selective_message_inbox smi_checker u_smi_checker (.*);

@@ verif/selective_message_inbox_tb.sv @@
// Testbench for selective_message_inbox: directed and random deliver/poll traffic,
// checked against an in-bench mailbox predictor with random idling on both sides.
// Depends on smi_pkg and the selective_message_inbox RTL.
`timescale 1ns / 100ps

module selective_message_inbox_tb;

	localparam int DEPTH = 16;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// op, msg_type, msg_sender, msg_payload, want_type, want_sender, zero fill
	logic [167:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// status, out_type, out_sender, out_payload, pending_count
	logic [119:0] m_tdata;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] mtype;
		logic [15:0] sender;
		logic [63:0] payload;
		logic [4:0]  pending;
	} reply_t;

	// predictor state: deferred inbox as an ordered queue, arrival ring as a queue
	smi_pkg::msg_t inbox_q[$];
	smi_pkg::msg_t ring_q[$];
	reply_t        replies_due[$];
	int            errors = 0;

	selective_message_inbox DUT (.*);

	always #5 clk = ~clk;

	function automatic bit wanted(smi_pkg::msg_t m, logic [31:0] wt,
			logic signed [16:0] ws);
		return m.mtype == wt && (ws <= 0 || $signed({1'b0, m.sender}) == ws);
	endfunction

	// one mailbox step; returns the reply the block should give
	function automatic reply_t mailbox_step(smi_pkg::op_t op, smi_pkg::msg_t m,
			logic [31:0] wt, logic signed [16:0] ws);
		reply_t r;
		smi_pkg::msg_t got;
		int i;
		bit hit;
		r = '0;
		r.status = smi_pkg::ST_NONE;
		hit = 1'b0;
		case (op)
			smi_pkg::OP_DELIVER: begin
				if (ring_q.size() >= DEPTH)
					r.status = smi_pkg::ST_OVERFLOW;
				else begin
					ring_q.push_back(m);
					r.status = smi_pkg::ST_DELIVERED;
				end
			end
			smi_pkg::OP_POLL: begin
				if (inbox_q.size() > 0) begin
					got = inbox_q.pop_front();
					r.status = smi_pkg::ST_READY;
				end else if (ring_q.size() > 0) begin
					got = ring_q.pop_front();
					r.status = smi_pkg::ST_READY;
				end
			end
			smi_pkg::OP_TYPED: begin
				for (i = 0; i < inbox_q.size(); i++)
					if (wanted(inbox_q[i], wt, ws)) begin
						got = inbox_q[i];
						inbox_q.delete(i);
						r.status = smi_pkg::ST_READY;
						hit = 1'b1;
						break;
					end
				// drain the ring, deferring non-matches
				for (i = 0; i < DEPTH && !hit; i++) begin
					if (inbox_q.size() >= DEPTH) begin
						r.status = smi_pkg::ST_FULL;
						break;
					end
					if (ring_q.size() == 0)
						break;
					got = ring_q.pop_front();
					if (wanted(got, wt, ws)) begin
						r.status = smi_pkg::ST_READY;
						hit = 1'b1;
					end else
						inbox_q.push_back(got);
				end
			end
			default: ;
		endcase
		if (r.status == smi_pkg::ST_READY) begin
			r.mtype = got.mtype;
			r.sender = got.sender;
			r.payload = got.payload;
		end
		r.pending = 5'(inbox_q.size());
		return r;
	endfunction

	// valid stays high into the next item when it follows with no idle cycle
	task automatic send_item(smi_pkg::op_t op, smi_pkg::msg_t m, logic [31:0] wt,
			logic signed [16:0] ws);
		int gap;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, ws, wt, m.payload, m.sender, m.mtype, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		replies_due.push_back(mailbox_step(op, m, wt, ws));
	endtask

	// result side: random stall per item, compare with oldest expectation
	initial begin
		reply_t got, exp;
		int wait_n;
		wait_n = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = {m_tdata[2:0], m_tdata[34:3], m_tdata[50:35], m_tdata[114:51],
					m_tdata[119:115]};
				if (replies_due.size() == 0) begin
					$display("%0t unexpected result %h", $time, got);
					errors++;
				end else begin
					exp = replies_due.pop_front();
					if (got.status !== exp.status || got.mtype !== exp.mtype
							|| got.sender !== exp.sender || got.payload !== exp.payload
							|| got.pending !== exp.pending) begin
						$display("%0t expected st=%0d t=%h s=%h p=%h n=%0d",
							$time, exp.status, exp.mtype, exp.sender, exp.payload,
							exp.pending);
						$display("%0t actual   st=%0d t=%h s=%h p=%h n=%0d",
							$time, got.status, got.mtype, got.sender, got.payload,
							got.pending);
						errors++;
					end
				end
				wait_n = $urandom_range(0, 9);
				if (wait_n > 0) m_tready <= 1'b0;
			end else if (!m_tready && arst_n) begin
				if (wait_n > 0) wait_n--;
				else m_tready <= 1'b1;
			end
		end
	end

	function automatic smi_pkg::msg_t rand_msg(int ntypes, int nsend);
		smi_pkg::msg_t m;
		m.mtype = ntypes > 0 ? $urandom_range(0, ntypes - 1) : $urandom;
		m.sender = 16'(nsend > 0 ? $urandom_range(0, nsend - 1) : $urandom);
		m.payload = {$urandom, $urandom};
		return m;
	endfunction

	task automatic test_directed;
		smi_pkg::msg_t m;
		int i;
		// empty polls and a reserved op
		send_item(smi_pkg::OP_POLL, '0, '0, '0);
		send_item(smi_pkg::OP_TYPED, '0, '0, -17'sd1);
		send_item(smi_pkg::OP_RSVD, '0, '0, '0);
		// field extremes
		m = {32'hFFFF_FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF};
		send_item(smi_pkg::OP_DELIVER, m, '0, '0);
		send_item(smi_pkg::OP_TYPED, '0, 32'hFFFF_FFFF, 17'sd65535);
		m = '0;
		send_item(smi_pkg::OP_DELIVER, m, '0, '0);
		send_item(smi_pkg::OP_POLL, '0, '0, '0);
		// fill the ring and overflow it
		for (i = 0; i < DEPTH; i++) begin
			m = {32'(i + 1), 16'(i), 64'(i * 3)};
			send_item(smi_pkg::OP_DELIVER, m, '0, '0);
		end
		m = {32'h5, 16'h5, 64'h5};
		send_item(smi_pkg::OP_DELIVER, m, '0, '0);
		// typed miss drains all into the inbox (drain limit)
		send_item(smi_pkg::OP_TYPED, '0, 32'h77, '0);
	endtask

	task automatic test_inbox_full;
		int i;
		// inbox holds 16 now; more ring items then a typed miss gives full
		for (i = 0; i < 3; i++) send_item(smi_pkg::OP_DELIVER, rand_msg(0, 0), '0, '0);
		send_item(smi_pkg::OP_TYPED, '0, 32'h99, 17'sd3);
		send_item(smi_pkg::OP_TYPED, '0, 32'h9, 17'sd8);
		send_item(smi_pkg::OP_POLL, '0, '0, '0);
		while (inbox_q.size() + ring_q.size() > 0)
			send_item(smi_pkg::OP_POLL, '0, '0, '0);
	endtask

	task automatic test_random;
		int i;
		int k;
		logic signed [16:0] ws;
		for (i = 0; i < 1150; i++) begin
			k = $urandom_range(0, 99);
			ws = $urandom_range(0, 9) == 0 ? 17'($urandom)
				: 17'($signed($urandom_range(0, 4)) - 1);
			if (k < 45)
				send_item(smi_pkg::OP_DELIVER, $urandom_range(0, 19) == 0 ? rand_msg(0, 0)
					: rand_msg(4, 4), '0, '0);
			else if (k < 65)
				send_item(smi_pkg::OP_POLL, '0, '0, '0);
			else if (k < 97)
				send_item(smi_pkg::OP_TYPED, '0, $urandom_range(0, 9) == 0 ? $urandom
					: $urandom_range(0, 4), ws);
			else
				send_item(smi_pkg::OP_RSVD, rand_msg(0, 0), $urandom, 17'($urandom));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_inbox_full();
		test_random();
		s_tvalid <= 1'b0;
		while (replies_due.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("selective_message_inbox: match");
		else
			$display("selective_message_inbox: mismatch");
		$finish;
	end

	initial begin
		#20ms;
		$display("selective_message_inbox: mismatch");
		$finish;
	end

endmodule
